/* design/lppw_pkg.sv */
`default_nettype none
package lppw_pkg;

  // default display geometry
  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 64;

  // controller command bytes
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [3:0] NIBBLE_MASK  = 4'hF;

  // position of each byte inside one burst
  localparam logic [1:0] BYTE_PAGE    = 2'd0;
  localparam logic [1:0] BYTE_COL_HI  = 2'd1;
  localparam logic [1:0] BYTE_COL_LO  = 2'd2;
  localparam logic [1:0] BYTE_DATA    = 2'd3;

  // pixel operation
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_KEEP   = 2'd3
  } draw_mode_t;

  // controller to datapath
  typedef struct packed {
    logic clear;    // write zero at the sweep address and advance
    logic capture;  // latch the request, its read is under way
    logic modify;   // write back the updated byte, start the burst
    logic advance;  // step to the next byte of the burst
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last entry
    logic on_screen;   // request at the input lies on the display
    logic burst_last;  // data byte is being presented
  } ctl_stat_t;

endpackage
`default_nettype wire

/* design/lcd_pixel_plot_page_writer.sv */
`default_nettype none
// channel | handshake            | payload
// in      | in_valid / in_stall   | in_x_pos, in_y_pos, in_draw_mode
// out     | out_valid / out_stall | out_spi_byte, out_is_data, out_last_of_burst
//
// after reset a sweep writes zero to every column byte, one per cycle, over all
// ((HEIGHT+7)/8)*WIDTH bytes (1024 at the defaults), input stalled meanwhile.
// an on-screen request does a read-modify-write on the frame store (read and
// write port), then 4 transfers: page, column high, column low and data byte.
// an off-screen request is taken and gives no transfers.
// out_stall holds the current byte; the input stays stalled until the burst ends.
module lcd_pixel_plot_page_writer #(
  parameter int WIDTH  = lppw_pkg::DEF_WIDTH,
  parameter int HEIGHT = lppw_pkg::DEF_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_x_pos,
  input  wire logic [7:0] in_y_pos,
  input  wire logic [1:0] in_draw_mode,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_spi_byte,
  output logic            out_is_data,
  output logic            out_last_of_burst
);
  import lppw_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencing
  lppw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // frame store and burst bytes
  lppw_datapath #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_draw_mode     (in_draw_mode),
    .out_spi_byte     (out_spi_byte),
    .out_is_data      (out_is_data),
    .out_last_of_burst(out_last_of_burst)
  );

endmodule
`default_nettype wire

/* design/lppw_ram.sv */
`default_nettype none
module lppw_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/lppw_datapath.sv */
`default_nettype none
module lppw_datapath #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lppw_pkg::ctl_cmd_t   cmd,
  output lppw_pkg::ctl_stat_t       stat,
  input  wire logic [7:0]           in_x_pos,
  input  wire logic [7:0]           in_y_pos,
  input  wire logic [1:0]           in_draw_mode,
  output logic      [7:0]           out_spi_byte,
  output logic                      out_is_data,
  output logic                      out_last_of_burst
);
  import lppw_pkg::*;

  localparam int PAGES  = (HEIGHT + 7) / 8;
  localparam int DEPTH  = PAGES * WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [8:0] WIDTH_LIM  = 9'(WIDTH);
  localparam logic [8:0] HEIGHT_LIM = 9'(HEIGHT);

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        x_r;
  logic [2:0]        page_r;
  logic [2:0]        bit_r;
  draw_mode_t        mode_r;
  logic [7:0]        byte_r;
  logic [1:0]        cnt_r, cnt_nxt;

  logic [2:0]        in_page;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [7:0]        bit_mask;
  logic [7:0]        new_byte;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  // column byte address of the request at the input
  assign in_page = in_y_pos[5:3];
  assign rd_addr = ADDR_W'(in_page) * WIDTH_A + ADDR_W'(in_x_pos);

  assign stat.on_screen  = ({1'b0, in_x_pos} < WIDTH_LIM) &&
                           ({1'b0, in_y_pos} < HEIGHT_LIM);
  assign stat.clear_last = (clr_cnt_r == LAST_ADDR);
  assign stat.burst_last = (cnt_r == BYTE_DATA);

  // apply the pixel operation to the stored byte
  assign bit_mask = 8'd1 << bit_r;
  always_comb begin
    unique case (mode_r)
      MODE_CLEAR:  new_byte = rd_data & ~bit_mask;
      MODE_SET:    new_byte = rd_data | bit_mask;
      MODE_TOGGLE: new_byte = rd_data ^ bit_mask;
      MODE_KEEP:   new_byte = rd_data;
      default:     new_byte = rd_data;
    endcase
  end

  // write port shared by the clearing sweep and the write back
  assign ram_we    = cmd.clear | cmd.modify;
  assign ram_waddr = cmd.clear ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clear ? 8'd0 : new_byte;

  lppw_ram #(
    .DATA_W(8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // sweep counter and burst byte index
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clear) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (cmd.modify) begin
      cnt_nxt = BYTE_PAGE;
    end else if (cmd.advance) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      cnt_r     <= BYTE_PAGE;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // request and updated byte
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= rd_addr;
      x_r    <= in_x_pos;
      page_r <= in_page;
      bit_r  <= in_y_pos[2:0];
      mode_r <= draw_mode_t'(in_draw_mode);
    end
    if (cmd.modify) begin
      byte_r <= new_byte;
    end
  end

  // burst byte selection
  always_comb begin
    unique case (cnt_r)
      BYTE_PAGE:   out_spi_byte = CMD_PAGE + {5'd0, page_r};
      BYTE_COL_HI: out_spi_byte = CMD_COL_HIGH + {4'd0, x_r[7:4] & NIBBLE_MASK};
      BYTE_COL_LO: out_spi_byte = {4'd0, x_r[3:0] & NIBBLE_MASK};
      BYTE_DATA:   out_spi_byte = byte_r;
      default:     out_spi_byte = byte_r;
    endcase
  end

  assign out_is_data       = (cnt_r == BYTE_DATA);
  assign out_last_of_burst = (cnt_r == BYTE_DATA);

endmodule
`default_nettype wire

/* design/lppw_ctrl.sv */
`default_nettype none
module lppw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire lppw_pkg::ctl_stat_t  stat,
  output lppw_pkg::ctl_cmd_t        cmd
);
  import lppw_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.on_screen) begin
            state_nxt = ST_MODIFY;
          end
        end
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
        state_nxt  = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) begin
          if (stat.burst_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    in_stall_nxt  = (state_nxt != ST_IDLE);
    out_valid_nxt = (state_nxt == ST_SEND);
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  // no request taken while the sweep runs
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall_r)
    else $error("input open during clearing sweep");

  // never take a request while a burst is being presented
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && !in_stall_r))
    else $error("input open while burst pending");

  // write back is followed by the burst
  a_modify_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODIFY) |=> (out_valid_r && stat.burst_last == 1'b0))
    else $error("burst did not start after write back");

  // the index never steps past the data byte
  a_advance_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> !stat.burst_last)
    else $error("burst index stepped past data byte");

endmodule
`default_nettype wire
